>>> rtl/core/tdp_pkg.sv
// ----------------------------------------------------------------------------
// tdp_pkg
// Shared types, constants and the control program of the trial-division
// prime tester.
// ----------------------------------------------------------------------------
package tdp_pkg;

    localparam int NUMBER_WIDTH_DEF = 16;
    // Remainder bits resolved per cycle by the shift-subtract unit
    localparam int STEP_BITS = 4;

    localparam int PC_W = 3;
    typedef logic [PC_W-1:0] t_pc;

    localparam t_pc PC_IDLE  = 3'd0;
    localparam t_pc PC_SMALL = 3'd1;
    localparam t_pc PC_BOUND = 3'd2;
    localparam t_pc PC_DINIT = 3'd3;
    localparam t_pc PC_DSTEP = 3'd4;
    localparam t_pc PC_TEST  = 3'd5;
    localparam t_pc PC_EMIT  = 3'd6;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_IN_VALID,
        COND_N_SMALL,
        COND_SQ_GT_N,
        COND_DIV_DONE,
        COND_REM_ZERO,
        COND_OUT_FREE
    } t_cond;

    typedef struct packed {
        logic  ld_in;        // offer input ready, load the candidate on a beat
        logic  div_init;     // start a remainder computation
        logic  div_step;     // advance the remainder computation
        logic  clr_prime_t;  // drop the prime flag when the condition holds
        logic  next_div_f;   // advance the divisor when the condition fails
        logic  emit;         // load the output register when the condition holds
        t_cond cond;
        t_pc   jump_t;
        t_pc   jump_f;
    } t_ctl;

    function automatic t_ctl ctl_rom(input t_pc pc);
        t_ctl w;
        w = '0;
        case (pc)
            PC_IDLE: begin
                w.ld_in  = 1'b1;
                w.cond   = COND_IN_VALID;
                w.jump_t = PC_SMALL;
                w.jump_f = PC_IDLE;
            end
            PC_SMALL: begin
                w.clr_prime_t = 1'b1;
                w.cond        = COND_N_SMALL;
                w.jump_t      = PC_EMIT;
                w.jump_f      = PC_BOUND;
            end
            PC_BOUND: begin
                w.cond   = COND_SQ_GT_N;
                w.jump_t = PC_EMIT;
                w.jump_f = PC_DINIT;
            end
            PC_DINIT: begin
                w.div_init = 1'b1;
                w.cond     = COND_ALWAYS;
                w.jump_t   = PC_DSTEP;
                w.jump_f   = PC_DSTEP;
            end
            PC_DSTEP: begin
                w.div_step = 1'b1;
                w.cond     = COND_DIV_DONE;
                w.jump_t   = PC_TEST;
                w.jump_f   = PC_DSTEP;
            end
            PC_TEST: begin
                w.clr_prime_t = 1'b1;
                w.next_div_f  = 1'b1;
                w.cond        = COND_REM_ZERO;
                w.jump_t      = PC_EMIT;
                w.jump_f      = PC_BOUND;
            end
            PC_EMIT: begin
                w.emit   = 1'b1;
                w.cond   = COND_OUT_FREE;
                w.jump_t = PC_IDLE;
                w.jump_f = PC_EMIT;
            end
            default: begin
                w.cond   = COND_ALWAYS;
                w.jump_t = PC_IDLE;
                w.jump_f = PC_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

>>> rtl/core/tdp_if.sv
// ----------------------------------------------------------------------------
// tdp_if
// Valid/ready channels of the prime tester: candidate in, verdict out.
// ----------------------------------------------------------------------------
interface tdp_in_if #(
    parameter int W = tdp_pkg::NUMBER_WIDTH_DEF
);
    logic         valid;
    logic         ready;
    logic [W-1:0] candidate;

    modport source (output valid, output candidate, input ready);
    modport sink   (input valid, input candidate, output ready);
endinterface

interface tdp_out_if #(
    parameter int W = tdp_pkg::NUMBER_WIDTH_DEF
);
    logic         valid;
    logic         ready;
    logic [W-1:0] tested_value;
    logic         is_prime;

    modport source (output valid, output tested_value, output is_prime, input ready);
    modport sink   (input valid, input tested_value, input is_prime, output ready);
endinterface

>>> rtl/core/trial_division_prime_test_unit.sv
// ----------------------------------------------------------------------------
// trial_division_prime_test_unit
// Primality test by trial division, run by a small microcoded sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one candidate per beat; o_out returns one beat per candidate
//   with the candidate echoed and the prime verdict. Both are valid/ready.
//   One candidate is worked on at a time. Per divisor d the sequencer spends
//   one bound step (d*d > n), one remainder set-up step, steps of the
//   shift-subtract remainder unit (4 bits per cycle) until all W bits are
//   done, and one test step. Each candidate tries the divisors from 2 while
//   d*d <= n (at most 254 divisors for W = 16); 0 and 1 skip the divisor
//   loop and go straight to the verdict. The remainder loop sets the rate.
//   The verdict sits in an output register, so the next candidate is taken
//   while it waits; a stalled receiver holds the sequencer only when a
//   second verdict is ready to be written.
//   Reset returns the sequencer to its idle step and empties the output
//   register; no clearing pass is needed.
// ----------------------------------------------------------------------------
module trial_division_prime_test_unit #(
    parameter int NUMBER_WIDTH = tdp_pkg::NUMBER_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tdp_in_if.sink    i_in,
    tdp_out_if.source o_out
);

    localparam int CW = $clog2(NUMBER_WIDTH + 1);
    localparam int SW = NUMBER_WIDTH + 2;

    tdp_pkg::t_pc  r_pc;
    tdp_pkg::t_pc  n_pc;
    tdp_pkg::t_ctl ctl;

    logic [NUMBER_WIDTH-1:0] r_n;
    logic [NUMBER_WIDTH-1:0] r_d;
    logic [SW-1:0]           r_sq;
    logic [NUMBER_WIDTH-1:0] r_rem;
    logic [NUMBER_WIDTH-1:0] r_quo;
    logic [CW-1:0]           r_cnt;
    logic                    r_prime;
    logic                    r_out_valid;
    logic [NUMBER_WIDTH-1:0] r_out_val;
    logic                    r_out_prime;

    logic [NUMBER_WIDTH-1:0] n_rem;
    logic [NUMBER_WIDTH-1:0] n_quo;
    logic [NUMBER_WIDTH:0]   s_trial;
    logic                    s_cond;
    logic                    s_fire;

    assign ctl = tdp_pkg::ctl_rom(r_pc);

    always_comb begin
        case (ctl.cond)
            tdp_pkg::COND_ALWAYS:   s_cond = 1'b1;
            tdp_pkg::COND_IN_VALID: s_cond = i_in.valid;
            tdp_pkg::COND_N_SMALL:  s_cond = (r_n[NUMBER_WIDTH-1:1] == '0);
            tdp_pkg::COND_SQ_GT_N:  s_cond = (r_sq > {2'b00, r_n});
            tdp_pkg::COND_DIV_DONE:
                s_cond = (({1'b0, r_cnt} + (CW+1)'(tdp_pkg::STEP_BITS))
                          >= (CW+1)'(NUMBER_WIDTH));
            tdp_pkg::COND_REM_ZERO: s_cond = (r_rem == '0);
            tdp_pkg::COND_OUT_FREE: s_cond = !r_out_valid || o_out.ready;
            default:                s_cond = 1'b0;
        endcase
        n_pc = s_cond ? ctl.jump_t : ctl.jump_f;
    end

    assign s_fire = ctl.ld_in && i_in.valid;

    // Restoring remainder: a few bits per cycle, bits past the width skipped
    always_comb begin
        n_rem   = r_rem;
        n_quo   = r_quo;
        s_trial = '0;
        for (int k = 0; k < tdp_pkg::STEP_BITS; k++) begin
            if ((int'(r_cnt) + k) < NUMBER_WIDTH) begin
                s_trial = {n_rem, n_quo[NUMBER_WIDTH-1]};
                if (s_trial >= {1'b0, r_d}) begin
                    s_trial = s_trial - {1'b0, r_d};
                end
                n_rem = s_trial[NUMBER_WIDTH-1:0];
                n_quo = {n_quo[NUMBER_WIDTH-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= tdp_pkg::PC_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (ctl.emit && s_cond) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_n     <= i_in.candidate;
            r_d     <= NUMBER_WIDTH'(2);
            r_sq    <= SW'(4);
            r_prime <= 1'b1;
        end
        if (ctl.div_init) begin
            r_rem <= '0;
            r_quo <= r_n;
            r_cnt <= '0;
        end
        if (ctl.div_step) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_cnt <= r_cnt + CW'(tdp_pkg::STEP_BITS);
        end
        if (ctl.clr_prime_t && s_cond) begin
            r_prime <= 1'b0;
        end
        // (d+1)^2 = d^2 + 2d + 1
        if (ctl.next_div_f && !s_cond) begin
            r_d  <= r_d + NUMBER_WIDTH'(1);
            r_sq <= r_sq + SW'({r_d, 1'b1});
        end
        if (ctl.emit && s_cond) begin
            r_out_val   <= r_n;
            r_out_prime <= r_prime;
        end
    end

    assign i_in.ready         = ctl.ld_in;
    assign o_out.valid        = r_out_valid;
    assign o_out.tested_value = r_out_val;
    assign o_out.is_prime     = r_out_prime;

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the trial-division prime tester. Candidates go in over the input
// channel: first a fixed set of edge values, then random numbers biased
// towards small values with a share across the full range. Each accepted
// beat is given a verdict by trial division, and every output beat is
// compared with the oldest verdict still due. Random idle bursts are placed
// on both channels, apart from the closing stretch of the run.
// ----------------------------------------------------------------------------
module testbench;

    localparam int NUM_W        = tdp_pkg::NUMBER_WIDTH_DEF;
    localparam int RANDOM_ITEMS = 600;
    localparam int CALM_ITEMS   = 60;    // last beats sent without idling
    localparam int DRAIN_CYCLES = 2000;  // beyond the slowest single verdict

    typedef struct packed {
        logic [NUM_W-1:0] value;
        logic             prime;
    } t_verdict;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    tdp_in_if  #(.W(NUM_W)) in_ch ();
    tdp_out_if #(.W(NUM_W)) out_ch ();

    logic             drv_valid = 1'b0;
    logic [NUM_W-1:0] drv_cand  = '0;
    logic             drv_ready = 1'b0;

    assign in_ch.valid     = drv_valid;
    assign in_ch.candidate = drv_cand;
    assign out_ch.ready    = drv_ready;

    trial_division_prime_test_unit #(.NUMBER_WIDTH(NUM_W)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #10 i_clk = ~i_clk;

    logic [NUM_W-1:0] cands_pending[$];
    t_verdict         verdicts_due[$];
    int               cands_total  = 0;
    int               cands_taken  = 0;
    int               error_count  = 0;
    int               send_gap     = 0;
    int               recv_stall   = 0;
    logic             cand_beat    = 1'b0;

    function automatic logic divides_by_none(input logic [NUM_W-1:0] n);
        longint unsigned num;
        longint unsigned d;
        logic            verdict;
        num     = n;
        verdict = (num >= 2);
        for (d = 2; verdict && (d * d <= num); d++) begin
            if (num % d == 0)
                verdict = 1'b0;
        end
        return verdict;
    endfunction

    // Monitor: note input beats, predict, and check output beats
    always @(posedge i_clk) begin
        t_verdict got;
        t_verdict want;
        cand_beat <= i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            want.value = in_ch.candidate;
            want.prime = divides_by_none(in_ch.candidate);
            verdicts_due.push_back(want);
            cands_taken++;
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.value = out_ch.tested_value;
            got.prime = out_ch.is_prime;
            if (verdicts_due.size() == 0) begin
                $display("%0t: unexpected beat, value %0d prime %0b",
                         $time, got.value, got.prime);
                error_count++;
            end else begin
                want = verdicts_due.pop_front();
                if (got.value !== want.value) begin
                    $display("%0t: tested_value expected %0d actual %0d",
                             $time, want.value, got.value);
                    error_count++;
                end
                if (got.prime !== want.prime) begin
                    $display("%0t: is_prime for %0d expected %0b actual %0b",
                             $time, want.value, want.prime, got.prime);
                    error_count++;
                end
            end
        end
    end

    // Driver: hold the beat until taken, then advance or idle
    always @(negedge i_clk) begin
        if (i_rst_n && (!drv_valid || cand_beat)) begin
            if (send_gap > 0) begin
                drv_valid <= 1'b0;
                send_gap  <= send_gap - 1;
            end else if (cands_pending.size() > CALM_ITEMS && $urandom_range(0, 7) == 0) begin
                drv_valid <= 1'b0;
                send_gap  <= $urandom_range(0, 13);
            end else if (cands_pending.size() > 0) begin
                drv_valid <= 1'b1;
                drv_cand  <= cands_pending.pop_front();
            end else begin
                drv_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall in bursts while the run is not in its closing stretch
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (recv_stall > 0) begin
                drv_ready  <= 1'b0;
                recv_stall <= recv_stall - 1;
            end else if (cands_pending.size() > CALM_ITEMS && $urandom_range(0, 7) == 0) begin
                drv_ready  <= 1'b0;
                recv_stall <= $urandom_range(0, 13);
            end else begin
                drv_ready  <= 1'b1;
            end
        end
    end

    initial begin
        logic [NUM_W-1:0] edge_vals[$];
        int               pick;
        edge_vals = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd9, 16'd25,
                      16'd49, 16'd97, 16'd32767, 16'd32768, 16'h5555, 16'hAAAA,
                      16'd63001, 16'd65025, 16'd65519, 16'd65521, 16'd65533,
                      16'd65534, 16'd65535};
        foreach (edge_vals[k])
            cands_pending.push_back(edge_vals[k]);
        // Keep half the candidates small: large primes cost the longest loop
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
                cands_pending.push_back(NUM_W'($urandom_range(0, 1023)));
            else if (pick < 9)
                cands_pending.push_back(NUM_W'($urandom_range(0, (1 << NUM_W) - 1)));
            else
                cands_pending.push_back(
                    NUM_W'($urandom_range((1 << NUM_W) - 600, (1 << NUM_W) - 1)));
        end
        cands_total = cands_pending.size();

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (cands_taken < cands_total)
            @(posedge i_clk);
        while (verdicts_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && verdicts_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #100_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

>>> trial_division_prime_test_unit.f
rtl/core/tdp_pkg.sv
rtl/core/tdp_if.sv
rtl/core/trial_division_prime_test_unit.sv
tb/sv/testbench.sv
